>>> rtl/cc20_pkg.sv
// cc20_pkg: constants, types and helper functions for the chacha20 stream xor block
// no dependencies
package cc20_pkg;

  localparam int unsigned DoubleRoundsDefault = 10;
  localparam int unsigned PosW = 38;
  localparam int unsigned CtrW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  localparam logic [CfgIdxW-1:0] RegKey0   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNonce0 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNonce1 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStart  = 3'd6;

  typedef logic [15:0][31:0] cc20_block_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_WRITE,
    ST_READ,
    ST_OUT
  } cc20_state_t;

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
    rol32 = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic [31:0] d);
    logic [31:0] a1, b1, c1, d1;
    a1 = a + b;  d1 = rol32(d ^ a1, 16);
    c1 = c + d1; b1 = rol32(b ^ c1, 12);
    a1 = a1 + b1; d1 = rol32(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rol32(b1 ^ c1, 7);
    qr = {a1, b1, c1, d1};
  endfunction

  // one column or diagonal half round on the whole state
  function automatic cc20_block_t half_round(input cc20_block_t x, input logic diag);
    cc20_block_t y;
    logic [127:0] t;
    y = x;
    for (int i = 0; i < 4; i++) begin
      if (!diag) begin
        t = qr(x[i], x[4+i], x[8+i], x[12+i]);
        {y[i], y[4+i], y[8+i], y[12+i]} = t;
      end else begin
        t = qr(x[i], x[4+((i+1)%4)], x[8+((i+2)%4)], x[12+((i+3)%4)]);
        {y[i], y[4+((i+1)%4)], y[8+((i+2)%4)], y[12+((i+3)%4)]} = t;
      end
    end
    half_round = y;
  endfunction

endpackage

>>> rtl/cc20_stream_if.sv
// cc20_in_if, cc20_out_if and cc20_cfg_if: valid/ready channels of the block
// depends on cc20_pkg
interface cc20_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic first;
  logic last;
  modport source (output valid, output data_byte, output first, output last, input ready);
  modport sink (input valid, input data_byte, input first, input last, output ready);
endinterface

interface cc20_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic last_out;
  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink (input valid, input out_byte, input last_out, output ready);
endinterface

interface cc20_cfg_if import cc20_pkg::*;;
  logic valid;
  logic ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/chacha20_stream_xor.sv
// chacha20_stream_xor: byte-wise xor with the rfc 8439 chacha20 keystream
// depends on cc20_pkg and the channel interfaces
// One byte per beat. A byte inside the buffered 64-byte block passes through
// the memory read, the registered result and the output; a byte that enters a
// new block first runs 2*DOUBLE_ROUNDS half rounds in the shared half-round
// unit, then writes the 16 block words into the keystream memory, one word a
// cycle. The keystream block is a 16-word memory with registered read data.
module chacha20_stream_xor import cc20_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = DoubleRoundsDefault
) (
  input  logic clk,
  input  logic rst_n,
  cc20_in_if.sink   in_ch,
  cc20_out_if.source out_ch,
  cc20_cfg_if.sink  cfg_ch
);

  localparam int unsigned RndW = $clog2(2*DOUBLE_ROUNDS);

  logic [3:0][63:0] key_r;
  logic [63:0] nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [PosW-1:0] start_r;

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [CtrW-1:0] buf_idx_r, buf_idx_nxt;
  logic buf_valid_r, buf_valid_nxt;
  cc20_state_t state_r, state_nxt;
  logic [RndW-1:0] rnd_r, rnd_nxt;
  logic [3:0] widx_r, widx_nxt;
  cc20_block_t work_r, work_nxt, init_w;
  logic [7:0] data_r;
  logic last_r;
  logic [31:0] ks_mem [16];
  logic [31:0] rd_r;
  logic [31:0] ks_wr;
  logic [7:0] out_byte_r;
  logic last_out_r;

  logic in_acc, cfg_acc;
  logic [PosW-1:0] use_pos;
  logic [CtrW-1:0] ctr;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid;
  assign use_pos = in_ch.first ? start_r : pos_r;
  assign ctr = use_pos[PosW-1:6];
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last_out = last_out_r;
  assign ks_wr = work_r[widx_r] + init_w[widx_r];

  always_comb begin
    init_w = '0;
    init_w[0] = Sigma0; init_w[1] = Sigma1; init_w[2] = Sigma2; init_w[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      init_w[4+2*i] = key_r[i][31:0];
      init_w[5+2*i] = key_r[i][63:32];
    end
    init_w[12] = buf_idx_r;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!buf_valid_r || buf_idx_r != ctr) state_nxt = ST_ROUND;
          else state_nxt = ST_READ;
        end
      end
      ST_ROUND: if (rnd_r == RndW'(2*DOUBLE_ROUNDS-1)) state_nxt = ST_WRITE;
      ST_WRITE: if (widx_r == 4'd15) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    buf_idx_nxt = buf_idx_r;
    buf_valid_nxt = buf_valid_r;
    rnd_nxt = rnd_r;
    widx_nxt = widx_r;
    work_nxt = work_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt = use_pos;
          rnd_nxt = '0;
          widx_nxt = '0;
          if (!buf_valid_r || buf_idx_r != ctr) begin
            buf_idx_nxt = ctr;
            buf_valid_nxt = 1'b0;
          end
        end
      end
      ST_ROUND: begin
        work_nxt = half_round((rnd_r == '0) ? init_w : work_r, rnd_r[0]);
        rnd_nxt = rnd_r + 1'b1;
      end
      ST_WRITE: begin
        widx_nxt = widx_r + 1'b1;
        if (widx_r == 4'd15) buf_valid_nxt = 1'b1;
      end
      ST_READ: pos_nxt = pos_r + 1'b1;
      ST_OUT: ;
      default: ;
    endcase
    if (cfg_acc && cfg_ch.index <= RegNonce1) buf_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r <= '0;
      buf_idx_r <= '0;
      buf_valid_r <= 1'b0;
      rnd_r <= '0;
      widx_r <= '0;
      key_r <= '0;
      nonce_lo_r <= '0;
      nonce_hi_r <= '0;
      start_r <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      buf_idx_r <= buf_idx_nxt;
      buf_valid_r <= buf_valid_nxt;
      rnd_r <= rnd_nxt;
      widx_r <= widx_nxt;
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          RegKey0:   key_r[0] <= cfg_ch.data;
          RegKey1:   key_r[1] <= cfg_ch.data;
          RegKey2:   key_r[2] <= cfg_ch.data;
          RegKey3:   key_r[3] <= cfg_ch.data;
          RegNonce0: nonce_lo_r <= cfg_ch.data;
          RegNonce1: nonce_hi_r <= cfg_ch.data[31:0];
          RegStart:  start_r <= cfg_ch.data[PosW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload and keystream memory
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (in_acc) begin
      data_r <= in_ch.data_byte;
      last_r <= in_ch.last;
    end
    if (state_r == ST_WRITE) ks_mem[widx_r] <= ks_wr;
    // forward the word being written when it is the one addressed
    if (state_r == ST_WRITE && widx_r == pos_nxt[5:2]) rd_r <= ks_wr;
    else rd_r <= ks_mem[pos_nxt[5:2]];
    if (state_r == ST_READ) begin
      out_byte_r <= data_r ^ 8'(rd_r >> {pos_r[1:0], 3'b000});
      last_out_r <= last_r;
    end
  end

  // read data registered in the cycle before ST_READ
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.out_byte))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ch.ready)
    else $error("input accepted while busy");
  a_buf_before_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ && !$past(cfg_acc) |-> buf_valid_r || $past(cfg_acc))
    else $error("read of unfilled block");
  a_round_to_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRITE && $past(state_r) == ST_ROUND |->
    $past(rnd_r) == RndW'(2*DOUBLE_ROUNDS-1))
    else $error("round count skipped");

endmodule

>>> tb/chacha20_stream_xor_tb.sv
// chacha20_stream_xor_tb: random and directed check of the chacha20 byte stream xor
// depends on cc20_pkg, the channel interfaces and chacha20_stream_xor
// an in-bench keystream predictor checks every output beat in order
module chacha20_stream_xor_tb;
  import cc20_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned TailCycles = 80;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
  } byte_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } xor_beat_t;

  logic clk;
  logic rst_n;

  cc20_in_if  in_ch ();
  cc20_out_if out_ch ();
  cc20_cfg_if cfg_ch ();

  chacha20_stream_xor u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor state
  logic [63:0]     key_q [4];
  logic [63:0]     nonce_lo_q;
  logic [31:0]     nonce_hi_q;
  logic [PosW-1:0] start_q;
  logic [PosW-1:0] pos_q;
  logic [31:0]     ks_words [16];
  logic [CtrW-1:0] ks_ctr;
  logic            ks_valid;

  byte_beat_t pending_beats [$];
  xor_beat_t  expected_xor [$];
  byte_beat_t cur_beat;
  int unsigned errors;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_mode;
  int unsigned rx_left;
  logic [7:0]  rx_mask;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  task automatic mix(inout logic [31:0] w[16], input int a, input int b, input int c,
                     input int d);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
  endtask

  task automatic build_keystream(input logic [CtrW-1:0] ctr);
    logic [31:0] init[16];
    logic [31:0] w[16];
    init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      init[4+2*i] = key_q[i][31:0];
      init[5+2*i] = key_q[i][63:32];
    end
    init[12] = ctr;
    init[13] = nonce_lo_q[31:0];
    init[14] = nonce_lo_q[63:32];
    init[15] = nonce_hi_q;
    w = init;
    for (int r = 0; r < DoubleRoundsDefault; r++) begin
      mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
      mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
      mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
      mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
    ks_ctr = ctr;
    ks_valid = 1'b1;
  endtask

  task automatic predict_xor(input byte_beat_t b);
    logic [CtrW-1:0] ctr;
    logic [31:0]     word;
    xor_beat_t       e;
    if (b.first) pos_q = start_q;
    ctr = pos_q[37:6];
    if (!ks_valid || ks_ctr != ctr) build_keystream(ctr);
    word = ks_words[pos_q[5:2]] >> (8 * pos_q[1:0]);
    e.out_byte = b.data_byte ^ word[7:0];
    e.last_out = b.last;
    expected_xor.push_back(e);
    pos_q = pos_q + 1'b1;
  endtask

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_xor(cur_beat);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          cur_beat = pending_beats.pop_front();
          in_ch.data_byte <= cur_beat.data_byte;
          in_ch.first <= cur_beat.first;
          in_ch.last <= cur_beat.last;
          in_ch.valid <= 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern and in-order check
  always @(posedge clk) begin
    xor_beat_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_xor.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, actual byte %h last %b", $time,
                   out_ch.out_byte, out_ch.last_out);
        end else begin
          e = expected_xor.pop_front();
          if (out_ch.out_byte !== e.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, e.out_byte,
                     out_ch.out_byte);
          end
          if (out_ch.last_out !== e.last_out) begin
            errors++;
            $display("%0t: last_out expected %b actual %b", $time, e.last_out,
                     out_ch.last_out);
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(1, 200);
        rx_mask = $urandom_range(1, 255);
      end else begin
        rx_left--;
      end
      rx_mask = {rx_mask[6:0], rx_mask[7]};
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= ($urandom_range(0, 4) == 0);
        default: out_ch.ready <= rx_mask[0];
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      RegKey0, RegKey1, RegKey2, RegKey3: begin
        key_q[idx] = val;
        ks_valid = 1'b0;
      end
      RegNonce0: begin
        nonce_lo_q = val;
        ks_valid = 1'b0;
      end
      RegNonce1: begin
        nonce_hi_q = val[31:0];
        ks_valid = 1'b0;
      end
      RegStart: start_q = val[PosW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    do @(posedge clk);
    while (pending_beats.size() > 0 || in_ch.valid || expected_xor.size() > 0);
  endtask

  task automatic push_beat(input logic [7:0] d, input logic f, input logic l);
    byte_beat_t b;
    b.data_byte = d;
    b.first = f;
    b.last = l;
    pending_beats.push_back(b);
  endtask

  task automatic push_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      push_beat($urandom_range(0, 255), i == 0, i == len - 1);
  endtask

  function automatic logic [63:0] rand64;
    rand64 = {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_start;
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, 200);
      1: v = 64 * $urandom_range(0, 1000) + 64 - $urandom_range(1, 3);
      2: v = {26'h3ffffff, 38'h3fffffffff} - $urandom_range(0, 100);
      3: v = rand64();
      default: v = 0;
    endcase
    pick_start = v;
  endfunction

  initial begin
    int unsigned budget;
    int unsigned len;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.first = 1'b0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = RegKey0;
    cfg_ch.data = 64'h0;
    for (int i = 0; i < 4; i++) key_q[i] = 64'h0;
    nonce_lo_q = 64'h0;
    nonce_hi_q = 32'h0;
    start_q = '0;
    pos_q = '0;
    ks_ctr = '0;
    ks_valid = 1'b0;
    for (int i = 0; i < 16; i++) ks_words[i] = 32'h0;
    errors = 0;
    cycles = 0;
    burst_left = 0;
    gap_left = 0;
    rx_mode = 0;
    rx_left = 0;
    rx_mask = 8'h5a;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b0;
    @(posedge clk);
    rst_n <= 1'b1;

    // reset config, no first: position from zero, extremes of the byte
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hff, 1'b0, 1'b1);
    push_beat(8'ha5, 1'b0, 1'b0);
    drain();

    // rfc style key and nonce, block boundary crossing
    write_reg(RegKey0, 64'h0706050403020100);
    write_reg(RegKey1, 64'h0f0e0d0c0b0a0908);
    write_reg(RegKey2, 64'h1716151413121110);
    write_reg(RegKey3, 64'h1f1e1d1c1b1a1918);
    write_reg(RegNonce0, 64'h4a00000000000000);
    write_reg(RegNonce1, 64'hffffffff00000000);
    write_reg(RegStart, 64'hffffffc000000040 - 64'd2);
    write_reg(RegUnused, 64'hffffffffffffffff);
    push_beat(8'h00, 1'b1, 1'b0);
    push_beat(8'hff, 1'b0, 1'b0);
    push_beat(8'h3c, 1'b0, 1'b0);
    push_beat(8'h81, 1'b0, 1'b1);
    push_beat(8'h11, 1'b0, 1'b0);
    push_beat(8'h22, 1'b1, 1'b1);
    drain();

    // counter wrap at the top of the position range
    write_reg(RegStart, 64'h0000003ffffffffe);
    push_beat(8'hff, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'h5a, 1'b0, 1'b0);
    push_beat(8'hc3, 1'b0, 1'b1);
    // start offset change takes effect only at the next first
    drain();
    write_reg(RegStart, 64'd63);
    push_beat(8'h01, 1'b0, 1'b0);
    push_beat(8'h02, 1'b1, 1'b0);
    push_beat(8'h03, 1'b0, 1'b1);
    drain();
    // extremes of key and nonce
    for (int i = 0; i < 6; i++) write_reg(i[CfgIdxW-1:0], 64'hffffffffffffffff);
    push_message(4);
    drain();

    budget = 1350;
    while (budget > 0) begin
      for (int i = 0; i < 7; i++)
        if ($urandom_range(0, 2) == 0)
          write_reg(i[CfgIdxW-1:0], (i == int'(RegStart)) ? pick_start() : rand64());
      if ($urandom_range(0, 5) == 0) write_reg(RegUnused, rand64());
      for (int m = 0; m < 8 && budget > 0; m++) begin
        if ($urandom_range(0, 9) == 0) begin
          len = $urandom_range(1, 6);
          for (int unsigned k = 0; k < len; k++)
            push_beat($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 140) : $urandom_range(1, 30);
          push_message(len);
        end
        budget = (budget > len) ? budget - len : 0;
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk);
    if (errors == 0 && expected_xor.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
